FILE: src/kmv_pkg.sv
// Shared types and constants of the 0/1 knapsack solver.
// Used by the best-value table and by the top level; depends on nothing.
`default_nettype none

package kmv_pkg;

	localparam int COST_W       = 12;
	localparam int ITEM_VALUE_W = 16;
	localparam int VALUE_W      = 28;
	localparam int BUDGET_W     = 12;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	// Operation issued to the table in one cycle.
	typedef enum logic [1:0] {
		TBL_NOP,
		TBL_UPDATE,
		TBL_READ,
		TBL_CLEAR
	} tbl_op_t;

endpackage

`default_nettype wire

FILE: src/kmv_table.sv
// Best-value table: one synchronous memory with two read ports and one
// write port, plus the saturating add and max of the update. Uses kmv_pkg.
`default_nettype none

module kmv_table #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  kmv_pkg::tbl_op_t              op,
	input  wire  [$clog2(TABLE_DEPTH)-1:0]      addr_a,
	input  wire  [$clog2(TABLE_DEPTH)-1:0]      addr_b,
	input  wire  [kmv_pkg::ITEM_VALUE_W-1:0]    item_value,
	output logic [kmv_pkg::VALUE_W-1:0]         rd_data
);
	import kmv_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [VALUE_W-1:0]      mem [TABLE_DEPTH];
	logic [VALUE_W-1:0]      rd_a_s1;
	logic [VALUE_W-1:0]      rd_b_s1;
	logic [AW-1:0]           addr_s1;
	logic [ITEM_VALUE_W-1:0] value_s1;
	tbl_op_t                 op_s1;

	logic [VALUE_W:0]        sum;
	logic [VALUE_W-1:0]      cand;
	logic [VALUE_W-1:0]      upd_data;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [VALUE_W-1:0]      wr_data;

	// Entry addr_a is the target, addr_b the entry one object cost below it.
	// The pass runs downward, so addr_b has not been rewritten in this pass.
	always_comb begin
		sum      = {1'b0, rd_b_s1} + (VALUE_W + 1)'(value_s1);
		cand     = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
		upd_data = (cand > rd_a_s1) ? cand : rd_a_s1;
		if (op_s1 == TBL_UPDATE) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			wr_data = upd_data;
		end else if (op == TBL_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = addr_a;
			wr_data = '0;
		end else begin
			wr_en   = 1'b0;
			wr_addr = addr_a;
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_s1  <= mem[addr_a];
		rd_b_s1  <= mem[addr_b];
		addr_s1  <= addr_a;
		value_s1 <= item_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= TBL_NOP;
		end else begin
			op_s1 <= op;
		end
	end

	assign rd_data = rd_a_s1;

endmodule

`default_nettype wire

FILE: src/knapsack_01_max_value.sv
// Top level of the 0/1 knapsack solver: control sequencer, budget register
// and result register around kmv_table. Uses kmv_pkg.
`default_nettype none

// Each object transaction sweeps the best-value table from entry TABLE_DEPTH-1
// down to the object's cost, one read-modify-write per cycle through the
// table's single write port; an object costing more than the top entry only
// passes through ST_DRAIN. After the object marked last_item the block reads
// the entry at the budget (saturated to the top entry), places it in the
// output register and then zeroes the table, one entry a cycle. The same
// clearing pass runs after reset; no object is taken during it, while budget
// writes are taken at any time. The output register lets the next problem
// start while a result waits to be taken.

module knapsack_01_max_value #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [kmv_pkg::BUDGET_W-1:0]        cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [kmv_pkg::COST_W-1:0]          item_cost,
	input  wire  [kmv_pkg::ITEM_VALUE_W-1:0]    item_value,
	input  wire                                 last_item,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [kmv_pkg::VALUE_W-1:0]         best_value
);
	import kmv_pkg::*;

	localparam int            AW       = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] TOP_ADDR = AW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_DRAIN,
		ST_READ,
		ST_CAPTURE
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           cnt_q;
	logic [AW-1:0]           cost_q;
	logic [ITEM_VALUE_W-1:0] value_q;
	logic                    last_q;
	logic [BUDGET_W-1:0]     budget_q;
	logic                    out_valid_q;
	logic [VALUE_W-1:0]      best_value_q;

	tbl_op_t                 op;
	logic [AW-1:0]           addr_a;
	logic [AW-1:0]           addr_b;
	logic [AW-1:0]           cap_addr;
	logic [VALUE_W-1:0]      rd_data;
	logic                    in_fire;
	logic                    out_free;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign best_value = best_value_q;
	// The result register may be loaded when it is empty or is being emptied.
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		if (32'(budget_q) > TABLE_DEPTH - 1) begin
			cap_addr = TOP_ADDR;
		end else begin
			cap_addr = AW'(budget_q);
		end
	end

	always_comb begin
		op     = TBL_NOP;
		addr_a = cnt_q;
		addr_b = cnt_q - cost_q;
		unique case (state_q)
			ST_CLEAR: begin
				op = TBL_CLEAR;
			end
			ST_UPDATE: begin
				op = TBL_UPDATE;
			end
			ST_READ: begin
				addr_a = cap_addr;
				if (out_free) begin
					op = TBL_READ;
				end
			end
			default: begin
				op = TBL_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cost_q  <= AW'(item_cost);
			value_q <= item_value;
		end
		if (state_q == ST_CAPTURE) begin
			best_value_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= TOP_ADDR;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						last_q <= last_item;
						cnt_q  <= TOP_ADDR;
						// An object costing more than the top entry changes nothing.
						if (32'(item_cost) > TABLE_DEPTH - 1) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					if (cnt_q == cost_q) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					// The final write of the pass lands at the end of this cycle.
					state_q <= last_q ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_CAPTURE;
					end
				end
				ST_CAPTURE: begin
					out_valid_q <= 1'b1;
					cnt_q       <= TOP_ADDR;
					state_q     <= ST_CLEAR;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	kmv_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.item_value(value_q),
		.rd_data   (rd_data)
	);

endmodule

`default_nettype wire

FILE: test/knapsack_01_max_value_tb.sv
// Self-checking testbench for knapsack_01_max_value: a directed table of objects, then random
// problems, with each result compared against a known value or a best-value table kept in the bench.
// Depends on kmv_pkg and the knapsack_01_max_value top level.
`default_nettype none

module knapsack_01_max_value_tb;
	import kmv_pkg::*;

	localparam int TABLE_DEPTH   = 4096;
	localparam int ITEM_TARGET   = 140;
	localparam int MAX_IDLE      = 14;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int DIRECTED_ROWS = 22;

	typedef struct packed {
		bit                      set_budget;
		logic [BUDGET_W-1:0]     budget;
		logic [COST_W-1:0]       cost;
		logic [ITEM_VALUE_W-1:0] value;
		bit                      last;
		bit                      known;
		logic [VALUE_W-1:0]      known_best;
	} object_row_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_we     = 1'b0;
	logic [BUDGET_W-1:0]     cfg_wdata  = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [COST_W-1:0]       item_cost  = '0;
	logic [ITEM_VALUE_W-1:0] item_value = '0;
	logic                    last_item  = 1'b0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [VALUE_W-1:0]      best_value;

	// Entry c holds the best value at total cost c or less for the current problem.
	logic [VALUE_W-1:0]  best_at_cost [TABLE_DEPTH];
	logic [BUDGET_W-1:0] budget_shadow = '0;
	logic [VALUE_W-1:0]  pending_best [$];
	int                  mismatch_count = 0;
	int                  objects_sent   = 0;

	object_row_t directed_rows [DIRECTED_ROWS] = '{
		// A zero budget admits nothing.
		'{1'b1, 12'd0,    12'd1,    16'd100,   1'b1, 1'b1, 28'd0},
		// Largest cost and value at the largest budget.
		'{1'b1, 12'd4095, 12'd4095, 16'hFFFF,  1'b1, 1'b1, 28'd65535},
		'{1'b0, 12'd0,    12'd1,    16'd0,     1'b1, 1'b1, 28'd0},
		// A zero-cost object is added once to every entry.
		'{1'b0, 12'd0,    12'd0,    16'd7,     1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd4095, 16'hFFFF,  1'b1, 1'b1, 28'd65542},
		'{1'b1, 12'd10,   12'd3,    16'd30,    1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd4,    16'd50,    1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd5,    16'd60,    1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd2,    16'd10,    1'b1, 1'b0, 28'd0},
		'{1'b1, 12'd4095, 12'hAAA,  16'h5555,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'h555,  16'hAAAA,  1'b1, 1'b0, 28'd0},
		'{1'b1, 12'd4094, 12'hAAA,  16'h5555,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'h555,  16'hAAAA,  1'b1, 1'b0, 28'd0},
		'{1'b1, 12'h800,  12'h400,  16'h8000,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'h400,  16'h7FFF,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd1,    16'hFFFF,  1'b1, 1'b0, 28'd0},
		// An object costing more than the budget leaves the result at zero.
		'{1'b0, 12'd0,    12'hFFF,  16'hFFFF,  1'b1, 1'b1, 28'd0},
		// Only three of the five unit-cost objects fit.
		'{1'b1, 12'd3,    12'd1,    16'hFFFF,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd1,    16'hFFFF,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd1,    16'hFFFF,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd1,    16'hFFFF,  1'b0, 1'b0, 28'd0},
		'{1'b0, 12'd0,    12'd1,    16'hFFFF,  1'b1, 1'b1, 28'd196605}
	};

	knapsack_01_max_value dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.item_cost  (item_cost),
		.item_value (item_value),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_value (best_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (best_at_cost[i])
			best_at_cost[i] = '0;
	end

	// Applies one object to the table; on the final object returns the best value and clears.
	function automatic bit fold_object(input logic [COST_W-1:0] cost,
			input logic [ITEM_VALUE_W-1:0] value, input bit last,
			output logic [VALUE_W-1:0] best);
		int               lowest;
		logic [VALUE_W:0] cand;
		lowest = int'(cost);
		best = '0;
		for (int c = TABLE_DEPTH - 1; c >= lowest; c--) begin
			cand = {1'b0, best_at_cost[c - lowest]} + (VALUE_W + 1)'(value);
			if (cand > {1'b0, VALUE_MAX})
				cand = {1'b0, VALUE_MAX};
			if (cand[VALUE_W-1:0] > best_at_cost[c])
				best_at_cost[c] = cand[VALUE_W-1:0];
		end
		if (!last)
			return 1'b0;
		// A 12-bit budget always lands inside the table.
		best = best_at_cost[budget_shadow];
		foreach (best_at_cost[i])
			best_at_cost[i] = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic check_best(input logic [VALUE_W-1:0] got);
		logic [VALUE_W-1:0] want;
		if (pending_best.size() == 0) begin
			report_mismatch("result with no problem pending", got, 'x);
			return;
		end
		want = pending_best.pop_front();
		if (got !== want)
			report_mismatch("best_value", got, want);
	endtask

	// Valid is left high after a transaction when the next object follows with no gap.
	task automatic send_object(input logic [COST_W-1:0] cost,
			input logic [ITEM_VALUE_W-1:0] value, input bit last, input bit eager,
			input bit known, input logic [VALUE_W-1:0] known_best);
		int                 gap;
		logic [VALUE_W-1:0] best;
		gap = eager ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		item_cost  <= cost;
		item_value <= value;
		last_item  <= last;
		do
			@(posedge clk);
		while (!in_ready);
		objects_sent++;
		if (fold_object(cost, value, last, best))
			pending_best.insert(pending_best.size(), known ? known_best : best);
	endtask

	// Holds off new objects until every result is out and the table clear has finished.
	task automatic settle_block();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_best.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_budget(input logic [BUDGET_W-1:0] budget);
		cfg_we    <= 1'b1;
		cfg_wdata <= budget;
		@(posedge clk);
		cfg_we <= 1'b0;
		budget_shadow = budget;
	endtask

	initial begin
		object_row_t             row;
		int                      length;
		bit                      eager;
		logic [COST_W-1:0]       cost;
		logic [ITEM_VALUE_W-1:0] value;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.set_budget) begin
				settle_block();
				write_budget(row.budget);
			end
			send_object(row.cost, row.value, row.last, 1'b0, row.known, row.known_best);
		end
		while (objects_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0) begin
				settle_block();
				case ($urandom_range(0, 5))
					0: write_budget('0);
					1: write_budget('1);
					default: write_budget(BUDGET_W'($urandom_range(0, 4095)));
				endcase
			end
			length = $urandom_range(1, 8);
			eager = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < length; k++) begin
				// High costs sweep few entries, so they keep the run short.
				case ($urandom_range(0, 3))
					0: cost = COST_W'($urandom_range(1, 64));
					1: cost = COST_W'($urandom_range(1, 4095));
					default: cost = COST_W'($urandom_range(2048, 4095));
				endcase
				case ($urandom_range(0, 7))
					0: value = '1;
					1: value = '0;
					default: value = ITEM_VALUE_W'($urandom());
				endcase
				send_object(cost, value, k == length - 1, eager, 1'b0, '0);
			end
		end
		settle_block();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			check_best(best_value);
		end
	end

	initial begin
		#80_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
